### sv/sbm_pkg.sv
package sbm_pkg;

  localparam logic [3:0] OP_AUX_TO_MAIN = 4'd0;
  localparam logic [3:0] OP_MAIN_TO_AUX = 4'd1;
  localparam logic [3:0] OP_INC         = 4'd2;
  localparam logic [3:0] OP_PUSH0       = 4'd3;
  localparam logic [3:0] OP_DUP         = 4'd4;
  localparam logic [3:0] OP_INPUT       = 4'd5;
  localparam logic [3:0] OP_PRINT       = 4'd6;
  localparam logic [3:0] OP_SUB         = 4'd7;
  localparam logic [3:0] OP_ADD         = 4'd8;
  localparam logic [3:0] OP_DROP        = 4'd9;
  localparam logic [3:0] OP_SWAP        = 4'd10;
  localparam logic [3:0] OP_ROTATE      = 4'd11;
  localparam logic [3:0] OP_MAIN_NONEMPTY = 4'd12;
  localparam logic [3:0] OP_AUX_NONEMPTY  = 4'd13;
  localparam logic [3:0] OP_EXIT        = 4'd14;
  localparam logic [3:0] OP_LOOP_TEST   = 4'd15;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SHALLOW = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_HALTED  = 2'd3;

  // Number of top cells that the controller can load directly.
  localparam int TOP_CELLS = 3;

  typedef struct packed {
    logic [3:0] opcode;
    logic [7:0] input_byte;
    logic       input_at_end;
  } req_t;

  typedef struct packed {
    logic       print_valid;
    logic [7:0] print_byte;
    logic       loop_taken;
    logic [1:0] status;
    logic       exit_request;
    logic [7:0] exit_code;
  } res_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_DEEPER,
    CMD_SHALLOWER,
    CMD_LOAD
  } cell_cmd_t;

  typedef enum logic [1:0] {
    SH_HOLD,
    SH_PUSH,
    SH_POP
  } shift_t;

  typedef struct packed {
    shift_t                        shift;
    logic [TOP_CELLS-1:0]          load;
    logic [TOP_CELLS-1:0][7:0]     load_data;
  } stack_ctrl_t;

endpackage

### sv/sbm_cell.sv
module sbm_cell import sbm_pkg::*; (
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic [7:0] shallower,
  input  logic [7:0] deeper,
  input  logic [7:0] load_data,
  output logic [7:0] value
);

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_DEEPER:    value <= deeper;
      CMD_SHALLOWER: value <= shallower;
      CMD_LOAD:      value <= load_data;
      default:       value <= value;
    endcase
  end

endmodule

### sv/sbm_stack.sv
module sbm_stack import sbm_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic                      clk,
  input  stack_ctrl_t               ctrl,
  output logic [TOP_CELLS-1:0][7:0] top
);

  // Cell 0 is the top of stack; a push moves every entry one cell deeper.
  logic [7:0] data [DEPTH];

  cell_cmd_t shift_cmd;

  always_comb begin
    case (ctrl.shift)
      SH_PUSH: shift_cmd = CMD_SHALLOWER;
      SH_POP:  shift_cmd = CMD_DEEPER;
      default: shift_cmd = CMD_HOLD;
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_cmd_t  cmd;
    logic [7:0] shallower;
    logic [7:0] deeper;
    logic [7:0] load_data;

    if (i < TOP_CELLS) begin : g_top
      assign cmd       = ctrl.load[i] ? CMD_LOAD : shift_cmd;
      assign load_data = ctrl.load_data[i];
      assign top[i]    = data[i];
    end else begin : g_body
      assign cmd       = shift_cmd;
      assign load_data = 8'h00;
    end

    if (i == 0) begin : g_first
      assign shallower = 8'h00;
    end else begin : g_inner
      assign shallower = data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign deeper = 8'h00;
    end else begin : g_more
      assign deeper = data[i+1];
    end

    sbm_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .shallower (shallower),
      .deeper    (deeper),
      .load_data (load_data),
      .value     (data[i])
    );
  end

endmodule

### sv/two_stack_byte_machine.sv
// Two-stack byte machine: one instruction per request on the req channel
// (req_valid / req_ready / req_data), one result per request on the res
// channel (res_valid / res_ready / res_data).
// Each stack is a row of byte cells with the top entry in cell 0; every
// instruction moves the whole row by at most one cell, and the top three
// cells can be loaded directly.
// The result is registered and shows on res in the cycle after the
// request is accepted. Throughput: one request per cycle while res_ready
// is high; the single result register sets that figure.
// When the receiver stalls, the result is held and req_ready drops until it
// is taken, so no further instruction executes.
// Reset (rst, synchronous) empties both stacks, clears the halt flag and
// drops res_valid; stack cells are not cleared and need no clearing pass.
// After an exit or an error every further request returns status halted.
module two_stack_byte_machine import sbm_pkg::*; #(
  parameter int STACK_DEPTH = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req_data,
  output logic res_valid,
  input  logic res_ready,
  output res_t res_data
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

  logic [CW-1:0] main_count, main_count_next;
  logic [CW-1:0] aux_count, aux_count_next;
  logic          halted, halted_next;
  res_t          result;

  stack_ctrl_t main_ctrl, aux_ctrl;
  logic [TOP_CELLS-1:0][7:0] main_top, aux_top;

  logic       fire;
  logic [1:0] need;
  logic       grow;
  logic       shallow, full;
  logic [7:0] a, b, c;

  assign req_ready = !res_valid || res_ready;
  assign fire      = req_valid && req_ready;

  assign a = main_top[0];
  assign b = main_top[1];
  assign c = main_top[2];

  always_comb begin
    need = 2'd0;
    grow = 1'b0;
    unique case (req_data.opcode)
      OP_AUX_TO_MAIN, OP_PUSH0, OP_INPUT,
      OP_MAIN_NONEMPTY, OP_AUX_NONEMPTY: grow = 1'b1;
      OP_DUP: begin
        need = 2'd1;
        grow = 1'b1;
      end
      OP_SUB, OP_ADD, OP_SWAP: need = 2'd2;
      OP_ROTATE:               need = 2'd3;
      default:                 need = 2'd1;
    endcase
  end

  always_comb begin
    unique case (req_data.opcode)
      OP_AUX_TO_MAIN: begin
        shallow = aux_count == '0;
        full    = main_count == FULL_COUNT;
      end
      OP_MAIN_TO_AUX: begin
        shallow = main_count == '0;
        full    = aux_count == FULL_COUNT;
      end
      default: begin
        shallow = main_count < CW'(need);
        full    = grow && main_count == FULL_COUNT;
      end
    endcase
  end

  always_comb begin
    main_ctrl       = '{shift: SH_HOLD, load: '0, load_data: '0};
    aux_ctrl        = '{shift: SH_HOLD, load: '0, load_data: '0};
    main_count_next = main_count;
    aux_count_next  = aux_count;
    halted_next     = halted;
    result          = '0;
    result.status   = ST_OK;

    if (halted) begin
      result.status = ST_HALTED;
    end else if (shallow) begin
      result.status = ST_SHALLOW;
      halted_next   = 1'b1;
    end else if (full) begin
      result.status = ST_FULL;
      halted_next   = 1'b1;
    end else begin
      unique case (req_data.opcode)
        OP_AUX_TO_MAIN: begin
          main_ctrl.shift        = SH_PUSH;
          main_ctrl.load[0]      = 1'b1;
          main_ctrl.load_data[0] = aux_top[0];
          aux_ctrl.shift         = SH_POP;
        end
        OP_MAIN_TO_AUX: begin
          main_ctrl.shift       = SH_POP;
          aux_ctrl.shift        = SH_PUSH;
          aux_ctrl.load[0]      = 1'b1;
          aux_ctrl.load_data[0] = a;
        end
        OP_INC: begin
          main_ctrl.load[0]      = 1'b1;
          main_ctrl.load_data[0] = a + 8'd1;
        end
        OP_PUSH0: begin
          main_ctrl.shift        = SH_PUSH;
          main_ctrl.load[0]      = 1'b1;
          main_ctrl.load_data[0] = 8'h00;
        end
        OP_DUP: begin
          // cell 1 picks up the old top by the shift itself
          main_ctrl.shift        = SH_PUSH;
          main_ctrl.load[0]      = 1'b1;
          main_ctrl.load_data[0] = a;
        end
        OP_INPUT: begin
          main_ctrl.shift        = SH_PUSH;
          main_ctrl.load[0]      = 1'b1;
          main_ctrl.load_data[0] = req_data.input_at_end ? 8'h00 : req_data.input_byte;
        end
        OP_PRINT: begin
          main_ctrl.shift    = SH_POP;
          result.print_valid = 1'b1;
          result.print_byte  = a;
        end
        OP_SUB: begin
          main_ctrl.shift        = SH_POP;
          main_ctrl.load[0]      = 1'b1;
          main_ctrl.load_data[0] = b - a;
        end
        OP_ADD: begin
          main_ctrl.shift        = SH_POP;
          main_ctrl.load[0]      = 1'b1;
          main_ctrl.load_data[0] = b + a;
        end
        OP_DROP: main_ctrl.shift = SH_POP;
        OP_SWAP: begin
          main_ctrl.load[1:0]      = 2'b11;
          main_ctrl.load_data[0]   = b;
          main_ctrl.load_data[1]   = a;
        end
        OP_ROTATE: begin
          // [.. c b a] -> [.. b a c]
          main_ctrl.load         = '1;
          main_ctrl.load_data[0] = c;
          main_ctrl.load_data[1] = a;
          main_ctrl.load_data[2] = b;
        end
        OP_MAIN_NONEMPTY: begin
          main_ctrl.shift        = SH_PUSH;
          main_ctrl.load[0]      = 1'b1;
          main_ctrl.load_data[0] = {7'd0, main_count != '0};
        end
        OP_AUX_NONEMPTY: begin
          main_ctrl.shift        = SH_PUSH;
          main_ctrl.load[0]      = 1'b1;
          main_ctrl.load_data[0] = {7'd0, aux_count != '0};
        end
        OP_EXIT: begin
          main_ctrl.shift     = SH_POP;
          result.exit_request = 1'b1;
          result.exit_code    = a;
          halted_next         = 1'b1;
        end
        default: begin
          main_ctrl.shift   = SH_POP;
          result.loop_taken = a != 8'h00;
        end
      endcase

      case (main_ctrl.shift)
        SH_PUSH: main_count_next = main_count + CW'(1);
        SH_POP:  main_count_next = main_count - CW'(1);
        default: main_count_next = main_count;
      endcase
      case (aux_ctrl.shift)
        SH_PUSH: aux_count_next = aux_count + CW'(1);
        SH_POP:  aux_count_next = aux_count - CW'(1);
        default: aux_count_next = aux_count;
      endcase
    end

    if (!fire) begin
      main_ctrl.shift = SH_HOLD;
      main_ctrl.load  = '0;
      aux_ctrl.shift  = SH_HOLD;
      aux_ctrl.load   = '0;
    end
  end

  sbm_stack #(.DEPTH(STACK_DEPTH)) u_main (
    .clk  (clk),
    .ctrl (main_ctrl),
    .top  (main_top)
  );

  sbm_stack #(.DEPTH(STACK_DEPTH)) u_aux (
    .clk  (clk),
    .ctrl (aux_ctrl),
    .top  (aux_top)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      main_count <= '0;
      aux_count  <= '0;
      halted     <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (fire) begin
        main_count <= main_count_next;
        aux_count  <= aux_count_next;
        halted     <= halted_next;
        res_valid  <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_data <= result;
    end
  end

endmodule

### sv/sbm_checker.sv
module sbm_checker import sbm_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req_data,
  input logic res_valid,
  input logic res_ready,
  input res_t res_data
);

  // set once a delivered result halts the machine
  logic seen_halt;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_halt <= 1'b0;
    end else if (res_valid && res_ready &&
                 (res_data.exit_request || res_data.status != ST_OK)) begin
      seen_halt <= 1'b1;
    end
  end

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result present right after reset");

  a_sticky_halt: assert property (@(posedge clk) disable iff (rst)
    res_valid && seen_halt |-> res_data.status == ST_HALTED)
    else $error("instruction executed after halt");

  a_side_effects_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.print_valid || res_data.exit_request || res_data.loop_taken)
      |-> res_data.status == ST_OK)
    else $error("side effect reported with error status");

endmodule

bind two_stack_byte_machine sbm_checker u_sbm_checker (.*);
